@@ design/ffei_pkg.sv @@
// ---------------------------------------------------------------------------
// ffei_pkg
// shared codes and defaults for the frame field extract/insert core
// ---------------------------------------------------------------------------
package ffei_pkg;

  // default depth of the frame byte store
  localparam int unsigned STORE_DEPTH_DEFAULT = 256;

  // reset value of the frame length register
  localparam logic [8:0] FRAME_LENGTH_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    VT_BOOL = 4'd0,
    VT_U8   = 4'd1,
    VT_U16  = 4'd2,
    VT_S16  = 4'd3,
    VT_U32  = 4'd4,
    VT_S32  = 4'd5,
    VT_U64  = 4'd6,
    VT_S8   = 4'd7,
    VT_F32  = 4'd8,
    VT_F64  = 4'd9
  } vtype_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_WIDTH = 3'd1,
    ERR_RANGE = 3'd2,
    ERR_FIT   = 3'd3,
    ERR_TYPE  = 3'd4
  } err_e;

  typedef enum logic {
    CFG_BYTE_ORDER   = 1'b0,
    CFG_FRAME_LENGTH = 1'b1
  } cfg_idx_e;

endpackage

@@ design/ffei_in_if.sv @@
// ---------------------------------------------------------------------------
// ffei_in_if
// request channel: one field operation or frame byte load per word
// ---------------------------------------------------------------------------
interface ffei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  byte_offset;
  logic [5:0]  bit_ofs;
  logic [6:0]  field_width;
  logic [3:0]  field_type;
  logic [63:0] write_value;
  logic [7:0]  load_byte;

  modport source (
    output valid, opcode, byte_offset, bit_ofs, field_width, field_type,
           write_value, load_byte,
    input  ready
  );

  modport sink (
    input  valid, opcode, byte_offset, bit_ofs, field_width, field_type,
           write_value, load_byte,
    output ready
  );
endinterface

@@ design/ffei_out_if.sv @@
// ---------------------------------------------------------------------------
// ffei_out_if
// response channel: decoded value and status per word
// ---------------------------------------------------------------------------
interface ffei_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [2:0]  error_code;

  modport source (
    output valid, read_value, error_code,
    input  ready
  );

  modport sink (
    input  valid, read_value, error_code,
    output ready
  );
endinterface

@@ design/frame_field_extract_insert_core.sv @@
// ---------------------------------------------------------------------------
// frame_field_extract_insert_core
// typed bit field read/write over a byte-wide frame store
// ---------------------------------------------------------------------------
// A frame store of STORE_DEPTH bytes (one synchronous single-port memory) is
// filled by load words and accessed by read and write words that name a
// typed field at byte_offset*8 + bit offset, field_width bits wide. Type,
// width, fit and frame range are checked first; a failing word returns its
// error code and leaves the store untouched. The core works on one word at a
// time: the field's n bytes (n = ceil((bit offset mod 8 + width)/8), at most
// 9) go through the memory port one at a time, each read in S_RD and then
// used or rewritten in S_MOD. A read then passes S_ALIGN and S_FIN; every
// word ends in S_DONE, and a load or a failing word goes there straight
// from S_CHECK. S_DONE posts the result once the output register is free,
// and no new word is taken before that, so the byte loop on the memory port
// sets the rate unless the output stalls. A finished result sits in an
// output register, so the next word is taken while it waits. The
// store has no reset; a field that covers bytes never loaded reads back
// undefined data.
// ---------------------------------------------------------------------------
module frame_field_extract_insert_core #(
  parameter int unsigned STORE_DEPTH = ffei_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  ffei_in_if.sink     in_if,
  ffei_out_if.source  out_if
);
  import ffei_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD, S_MOD, S_ALIGN, S_FIN, S_DONE
  } state_e;

  // exact width each type requires
  function automatic logic [6:0] type_width(input logic [3:0] vt);
    logic [6:0] w;
    case (vt)
      VT_BOOL:                w = 7'd1;
      VT_U8, VT_S8:           w = 7'd8;
      VT_U16, VT_S16:         w = 7'd16;
      VT_U32, VT_S32, VT_F32: w = 7'd32;
      VT_U64, VT_F64:         w = 7'd64;
      default:                w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] type_mask(input logic [3:0] vt);
    logic [63:0] m;
    case (vt)
      VT_BOOL:                m = 64'h1;
      VT_U8, VT_S8:           m = 64'hFF;
      VT_U16, VT_S16:         m = 64'hFFFF;
      VT_U32, VT_S32, VT_F32: m = 64'hFFFF_FFFF;
      default:                m = '1;
    endcase
    return m;
  endfunction

  // mask to the type width, sign-extend the signed types
  function automatic logic [63:0] type_extend(input logic [3:0] vt, input logic [63:0] x);
    logic [63:0] r;
    case (vt)
      VT_S8:   r = {{56{x[7]}}, x[7:0]};
      VT_S16:  r = {{48{x[15]}}, x[15:0]};
      VT_S32:  r = {{32{x[31]}}, x[31:0]};
      default: r = x & type_mask(vt);
    endcase
    return r;
  endfunction

  // configuration
  logic       byte_order_q;
  logic [8:0] frame_length_q;

  // captured word
  logic [1:0]  op_q;
  logic [7:0]  off_q;
  logic [5:0]  bo_q;
  logic [6:0]  w_q;
  logic [3:0]  vt_q;
  logic [63:0] wv_q;
  logic [7:0]  lb_q;

  // field walk
  state_e      state_q;
  logic        big_q;
  logic [3:0]  n_q;
  logic [3:0]  cnt_q;
  logic [8:0]  ptr_q;
  logic [71:0] acc_q;
  logic [71:0] data_q;
  logic [71:0] mask_q;
  logic [63:0] res_q;
  err_e        err_q;

  // result register
  logic        out_valid_q;
  logic [63:0] out_rv_q;
  logic [2:0]  out_err_q;

  // frame store
  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  // check stage
  logic [8:0]  usable;
  logic [11:0] field_lsb;
  logic [12:0] end_bit;
  logic [12:0] limit_bit;
  logic        fit_fail;
  err_e        chk_err;
  logic        chk_big;
  logic [3:0]  chk_n;
  logic [6:0]  big_shift;
  logic [63:0] wr_val;
  logic        load_ok;

  // byte step
  logic [7:0]  cur_data;
  logic [7:0]  cur_mask;
  logic [6:0]  align_shift;

  always_comb begin
    usable = (32'(frame_length_q) > STORE_DEPTH) ? 9'(STORE_DEPTH) : frame_length_q;
    field_lsb = 12'({off_q, 3'b000}) + 12'(bo_q);
    end_bit   = 13'(field_lsb) + 13'(w_q);
    limit_bit = 13'({usable, 3'b000});
    load_ok   = 32'(off_q) < STORE_DEPTH;

    case (vt_q)
      VT_U8:   fit_fail = (wv_q[63:8] != '0);
      VT_S8:   fit_fail = (wv_q[63:7] != '0) && (wv_q[63:7] != '1);
      VT_S16:  fit_fail = (wv_q[63:15] != '0) && (wv_q[63:15] != '1);
      VT_S32:  fit_fail = (wv_q[63:31] != '0) && (wv_q[63:31] != '1);
      default: fit_fail = 1'b0;
    endcase

    if (op_q == OP_LOAD) begin
      chk_err = ERR_OK;
    end else if ((op_q != OP_READ && op_q != OP_WRITE) || vt_q > VT_F64) begin
      chk_err = ERR_TYPE;
    end else if (w_q != type_width(vt_q) ||
                 ((vt_q == VT_F32 || vt_q == VT_F64) && bo_q != '0)) begin
      chk_err = ERR_WIDTH;
    end else if (op_q == OP_WRITE && fit_fail) begin
      chk_err = ERR_FIT;
    end else if (end_bit > limit_bit) begin
      chk_err = ERR_RANGE;
    end else begin
      chk_err = ERR_OK;
    end

    chk_big   = (bo_q == '0) && (w_q[2:0] == 3'd0) && byte_order_q;
    chk_n     = 4'((7'(bo_q[2:0]) + w_q + 7'd7) >> 3);
    big_shift = 7'({4'd9 - chk_n, 3'b000});
    wr_val    = ((vt_q == VT_BOOL) ? 64'(wv_q != '0) : wv_q) & type_mask(vt_q);

    // little endian walks up from the low byte, big endian from the top
    cur_data    = big_q ? data_q[71:64] : data_q[7:0];
    cur_mask    = big_q ? 8'hFF : mask_q[7:0];
    align_shift = 7'({4'd9 - n_q, 3'b000}) + 7'(bo_q[2:0]);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(ptr_q);
    mem_wdata = (mem_rdata_q & ~cur_mask) | (cur_data & cur_mask);
    case (state_q)
      S_CHECK: begin
        mem_addr  = AW'(off_q);
        mem_wdata = lb_q;
        mem_we    = (op_q == OP_LOAD) && load_ok;
      end
      S_MOD: begin
        mem_we = (op_q == OP_WRITE);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q   <= 1'b0;
      frame_length_q <= FRAME_LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYTE_ORDER:   byte_order_q   <= cfg_wdata_i[0];
        CFG_FRAME_LENGTH: frame_length_q <= cfg_wdata_i;
        default:          byte_order_q   <= byte_order_q;
      endcase
    end
  end

  assign in_if.ready       = (state_q == S_IDLE);
  assign out_if.valid      = out_valid_q;
  assign out_if.read_value = out_rv_q;
  assign out_if.error_code = out_err_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_rv_q    <= '0;
      out_err_q   <= '0;
      op_q        <= '0;
      off_q       <= '0;
      bo_q        <= '0;
      w_q         <= '0;
      vt_q        <= '0;
      wv_q        <= '0;
      lb_q        <= '0;
      big_q       <= 1'b0;
      n_q         <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      acc_q       <= '0;
      data_q      <= '0;
      mask_q      <= '0;
      res_q       <= '0;
      err_q       <= ERR_OK;
    end else begin
      // result word taken downstream; in S_DONE the refill below decides
      if (out_valid_q && out_if.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            op_q    <= in_if.opcode;
            off_q   <= in_if.byte_offset;
            bo_q    <= in_if.bit_ofs;
            w_q     <= in_if.field_width;
            vt_q    <= in_if.field_type;
            wv_q    <= in_if.write_value;
            lb_q    <= in_if.load_byte;
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          // loads write the store here through the port control
          err_q  <= chk_err;
          res_q  <= '0;
          big_q  <= chk_big;
          n_q    <= chk_n;
          cnt_q  <= '0;
          ptr_q  <= 9'(off_q) + 9'(bo_q[5:3]);
          acc_q  <= '0;
          data_q <= chk_big ? (72'(wr_val) << big_shift) : (72'(wr_val) << bo_q[2:0]);
          mask_q <= 72'(type_mask(vt_q)) << bo_q[2:0];
          if (op_q == OP_LOAD || chk_err != ERR_OK) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_RD;
          end
        end

        S_RD: begin
          // address is on the port, byte arrives next cycle
          state_q <= S_MOD;
        end

        S_MOD: begin
          acc_q  <= big_q ? {acc_q[63:0], mem_rdata_q} : {mem_rdata_q, acc_q[71:8]};
          data_q <= big_q ? {data_q[63:0], 8'h00} : {8'h00, data_q[71:8]};
          mask_q <= {8'h00, mask_q[71:8]};
          ptr_q  <= ptr_q + 9'd1;
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q + 4'd1 == n_q) begin
            state_q <= (op_q == OP_READ) ? S_ALIGN : S_DONE;
          end else begin
            state_q <= S_RD;
          end
        end

        S_ALIGN: begin
          // little endian bytes sit at the top, drop the unused low bits
          if (!big_q) begin
            acc_q <= acc_q >> align_shift;
          end
          state_q <= S_FIN;
        end

        S_FIN: begin
          res_q   <= type_extend(vt_q, acc_q[63:0]);
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_rv_q    <= res_q;
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/frame_field_extract_insert_core_tb.sv @@
// ---------------------------------------------------------------------------
// frame_field_extract_insert_core_tb
// self-checking bench for the typed field read/write core: a local model of
// the frame store predicts every response word, which is checked field by
// field as the core returns it, under several register settings and idling
// patterns
// ---------------------------------------------------------------------------
module frame_field_extract_insert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffei_pkg::*;

  // codes the package enums do not name
  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam logic [3:0] VT_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] VT_UNKNOWN_HI = 4'd15;

  localparam int unsigned STORE_BYTES = STORE_DEPTH_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_WORDS = 250;
  localparam int unsigned MAX_PRINTED = 50;

  // one request word, unpacked into its fields
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  vt;
    logic [7:0]  byte_off;
    logic [5:0]  bit_off;
    logic [6:0]  width;
    logic [63:0] wval;
    logic [7:0]  lbyte;
  } field_word_t;

  // one response word as the model sees it
  typedef struct {
    logic [63:0] value;
    err_e        err;
  } field_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [8:0] cfg_wdata_i;

  ffei_in_if  in_ch ();
  ffei_out_if out_ch ();

  frame_field_extract_insert_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // local copy of the store and of the two registers
  logic [7:0]  frame_mem [0:STORE_BYTES-1];
  logic        order_big;
  logic [8:0]  frame_len_q;

  // responses predicted but not yet returned, oldest first
  field_result_t awaited_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // model of the core
  // ------------------------------------------------------------------------

  // exact width each known type requires, zero for unknown codes
  function automatic int unsigned type_bits(input logic [3:0] vt);
    case (vt)
      VT_BOOL:                 return 1;
      VT_U8, VT_S8:            return 8;
      VT_U16, VT_S16:          return 16;
      VT_U32, VT_S32, VT_F32:  return 32;
      VT_U64, VT_F64:          return 64;
      default:                 return 0;
    endcase
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input int unsigned bits);
    logic [63:0] mask;
    if (bits == 0 || bits >= 64) return v;
    mask = (64'd1 << bits) - 64'd1;
    v = v & mask;
    if (v[bits-1]) v = v | ~mask;
    return v;
  endfunction

  // oversized length register values behave as a full store
  function automatic int unsigned frame_limit_bytes();
    return (frame_len_q > STORE_BYTES) ? STORE_BYTES : int'(frame_len_q);
  endfunction

  // runs one word against the local store and returns its response
  function automatic field_result_t apply_field_op(input field_word_t w);
    field_result_t r;
    int unsigned   start;
    int unsigned   n;
    int unsigned   pos;
    logic          big;
    logic          signed_t;
    logic [63:0]   wv;
    r.value = '0;
    r.err = ERR_OK;
    wv = w.wval;
    start = int'(w.byte_off) * 8 + int'(w.bit_off);
    signed_t = (w.vt == VT_S8 || w.vt == VT_S16 || w.vt == VT_S32);
    if (w.op == OP_LOAD) begin
      frame_mem[w.byte_off] = w.lbyte;
    end else if (w.op == OP_SPARE || w.vt > VT_F64) begin
      r.err = ERR_TYPE;
    end else if (w.width != type_bits(w.vt) ||
                 ((w.vt == VT_F32 || w.vt == VT_F64) && w.bit_off != 0)) begin
      r.err = ERR_WIDTH;
    end else begin
      // byte order only matters for aligned whole-byte fields
      big = (w.bit_off == 0) && (w.width[2:0] == 3'd0) && order_big;
      if (w.op == OP_WRITE) begin
        if (w.vt == VT_BOOL) wv = (wv != 64'd0) ? 64'd1 : 64'd0;
        else if (w.vt == VT_U8 && wv > 64'hFF) r.err = ERR_FIT;
        else if (signed_t && sign_ext(wv, w.width) != wv) r.err = ERR_FIT;
      end
      if (r.err == ERR_OK && start + w.width > frame_limit_bytes() * 8) r.err = ERR_RANGE;
      if (r.err == ERR_OK) begin
        n = w.width / 8;
        if (w.op == OP_READ) begin
          if (big) begin
            for (int i = 0; i < n; i++)
              r.value = {r.value[55:0], frame_mem[int'(w.byte_off) + i]};
          end else begin
            for (int i = 0; i < w.width; i++) begin
              pos = start + i;
              r.value[i] = frame_mem[pos / 8][pos % 8];
            end
          end
          if (signed_t) r.value = sign_ext(r.value, w.width);
        end else begin
          if (big) begin
            for (int i = 0; i < n; i++)
              frame_mem[int'(w.byte_off) + i] = 8'(wv >> ((n - 1 - i) * 8));
          end else begin
            for (int i = 0; i < w.width; i++) begin
              pos = start + i;
              frame_mem[pos / 8][pos % 8] = wv[i];
            end
          end
        end
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // monitors
  // ------------------------------------------------------------------------

  // every accepted request word is run through the model in order
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      field_word_t w;
      w.op = in_ch.opcode;
      w.vt = in_ch.field_type;
      w.byte_off = in_ch.byte_offset;
      w.bit_off = in_ch.bit_ofs;
      w.width = in_ch.field_width;
      w.wval = in_ch.write_value;
      w.lbyte = in_ch.load_byte;
      awaited_results.insert(awaited_results.size(), apply_field_op(w));
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // every accepted response word is checked against the oldest prediction
  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: value %h code %0d",
                                  out_ch.read_value, out_ch.error_code));
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.read_value !== want.value)
          report_mismatch($sformatf("read_value %h, predicted %h",
                                    out_ch.read_value, want.value));
        if (out_ch.error_code !== want.err)
          report_mismatch($sformatf("error_code %0d, predicted %0d",
                                    out_ch.error_code, want.err));
      end
    end
  end

  // response side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  function automatic field_word_t mk_word(input logic [1:0] op, input logic [3:0] vt,
                                          input logic [7:0] byte_off,
                                          input logic [5:0] bit_off,
                                          input logic [6:0] width,
                                          input logic [63:0] wval,
                                          input logic [7:0] lbyte);
    field_word_t w;
    w.op = op;
    w.vt = vt;
    w.byte_off = byte_off;
    w.bit_off = bit_off;
    w.width = width;
    w.wval = wval;
    w.lbyte = lbyte;
    return w;
  endfunction

  // field word with the width its type asks for
  function automatic field_word_t typed_word(input logic [1:0] op, input logic [3:0] vt,
                                             input logic [7:0] byte_off,
                                             input logic [5:0] bit_off,
                                             input logic [63:0] wval);
    return mk_word(op, vt, byte_off, bit_off, 7'(type_bits(vt)), wval, 8'h00);
  endfunction

  // mostly well-formed field accesses that land inside the frame, with
  // loads, wrong widths, unknown codes and out-of-range starts mixed in
  function automatic field_word_t random_field_word();
    field_word_t w;
    int unsigned roll;
    int unsigned span;
    int unsigned room;
    roll = $urandom_range(99);
    if (roll < 12)
      return mk_word(OP_LOAD, 4'($urandom_range(15)), 8'($urandom_range(255)),
                     6'($urandom_range(63)), 7'($urandom_range(127)),
                     {$urandom, $urandom}, 8'($urandom_range(255)));
    if (roll < 17)
      return mk_word(2'($urandom_range(3)), 4'($urandom_range(15)),
                     8'($urandom_range(255)), 6'($urandom_range(63)),
                     7'($urandom_range(127)), {$urandom, $urandom},
                     8'($urandom_range(255)));
    w.op = (roll < 58) ? OP_READ : OP_WRITE;
    w.vt = ($urandom_range(19) == 0) ? 4'($urandom_range(VT_UNKNOWN_HI, VT_UNKNOWN_LO))
                                     : 4'($urandom_range(VT_F64));
    w.lbyte = 8'($urandom_range(255));
    w.width = 7'(type_bits(w.vt));
    if (w.width == 0 || $urandom_range(11) == 0) w.width = 7'($urandom_range(127));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: w.bit_off = '0;
      5, 6, 7:       w.bit_off = 6'($urandom_range(7, 1));
      default:       w.bit_off = 6'($urandom_range(63));
    endcase
    // float types need a zero bit offset, so mostly keep to that
    if ((w.vt == VT_F32 || w.vt == VT_F64) && $urandom_range(7) != 0) w.bit_off = '0;
    // place the field inside the frame most of the time
    span = int'(w.bit_off) + int'(w.width);
    if ($urandom_range(9) != 0 && frame_limit_bytes() * 8 >= span) begin
      room = (frame_limit_bytes() * 8 - span) / 8;
      if (room > 255) room = 255;
      w.byte_off = 8'($urandom_range(room));
    end else begin
      w.byte_off = 8'($urandom_range(255));
    end
    case ($urandom_range(7))
      0:       w.wval = '1;
      1:       w.wval = '0;
      2, 3:    w.wval = {$urandom, $urandom};
      default: begin
        if (w.vt == VT_S8 || w.vt == VT_S16 || w.vt == VT_S32)
          w.wval = sign_ext({$urandom, $urandom}, type_bits(w.vt));
        else if (w.vt == VT_U8)
          w.wval = 64'($urandom_range(255));
        else if (w.vt == VT_BOOL)
          w.wval = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
        else
          w.wval = {$urandom, $urandom};
      end
    endcase
    return w;
  endfunction

  // offers one word, with random idle cycles ahead of it, until taken
  task automatic send_word(input field_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= w.op;
    in_ch.field_type  <= w.vt;
    in_ch.byte_offset <= w.byte_off;
    in_ch.bit_ofs     <= w.bit_off;
    in_ch.field_width <= w.width;
    in_ch.write_value <= w.wval;
    in_ch.load_byte   <= w.lbyte;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop offering and let every pending response come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BYTE_ORDER) order_big = data[0];
    else frame_len_q = data;
  endtask

  // registers only change once the core has gone quiet
  task automatic set_config(input logic big, input logic [8:0] len);
    wait_idle();
    write_cfg(CFG_BYTE_ORDER, {8'd0, big});
    write_cfg(CFG_FRAME_LENGTH, len);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // load every byte first so no field ever covers an unloaded byte
  task automatic test_fill_frame();
    for (int i = 0; i < STORE_BYTES; i++)
      send_word(mk_word(OP_LOAD, VT_BOOL, 8'(i), 6'd0, 7'd0, 64'd0,
                        8'($urandom_range(255))));
  endtask

  // type extremes, fit limits, frame end and error codes, little endian
  task automatic test_directed_fields();
    set_config(1'b0, 9'd256);
    send_word(typed_word(OP_READ,  VT_BOOL, 8'd0,   6'd0,  64'd0));
    send_word(typed_word(OP_READ,  VT_U8,   8'd255, 6'd0,  64'd0));
    // signed byte at its minimum, then one past its maximum
    send_word(typed_word(OP_WRITE, VT_S8,   8'd10,  6'd0,  64'hFFFF_FFFF_FFFF_FF80));
    send_word(typed_word(OP_READ,  VT_S8,   8'd10,  6'd0,  64'd0));
    send_word(typed_word(OP_WRITE, VT_S8,   8'd10,  6'd0,  64'd128));
    // unsigned byte fit
    send_word(typed_word(OP_WRITE, VT_U8,   8'd11,  6'd0,  64'd256));
    send_word(typed_word(OP_WRITE, VT_U8,   8'd11,  6'd0,  64'd255));
    // unaligned signed halfword straddling three bytes
    send_word(typed_word(OP_WRITE, VT_S16,  8'd12,  6'd3,  64'hFFFF_FFFF_FFFF_8000));
    send_word(typed_word(OP_READ,  VT_S16,  8'd12,  6'd3,  64'd0));
    send_word(typed_word(OP_WRITE, VT_S32,  8'd20,  6'd0,  64'h0000_0000_8000_0000));
    send_word(typed_word(OP_WRITE, VT_S32,  8'd20,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF));
    send_word(typed_word(OP_READ,  VT_S32,  8'd20,  6'd0,  64'd0));
    // last eight bytes fit, one byte later does not
    send_word(typed_word(OP_READ,  VT_U64,  8'd248, 6'd0,  64'd0));
    send_word(typed_word(OP_READ,  VT_U64,  8'd249, 6'd0,  64'd0));
    // range error on a write leaves the last byte alone
    send_word(typed_word(OP_WRITE, VT_U16,  8'd255, 6'd0,  64'hFFFF));
    send_word(typed_word(OP_READ,  VT_U8,   8'd255, 6'd0,  64'd0));
    // float bits need a zero bit offset
    send_word(typed_word(OP_READ,  VT_F32,  8'd4,   6'd0,  64'd0));
    send_word(typed_word(OP_READ,  VT_F32,  8'd4,   6'd1,  64'd0));
    send_word(typed_word(OP_READ,  VT_F64,  8'd0,   6'd0,  64'd0));
    // bool writes any nonzero value as one
    send_word(typed_word(OP_WRITE, VT_BOOL, 8'd30,  6'd5,  64'h8000_0000_0000_0000));
    send_word(typed_word(OP_READ,  VT_BOOL, 8'd30,  6'd5,  64'd0));
    // zero and wrong widths, unknown types, spare opcode
    send_word(mk_word(OP_READ, VT_U32, 8'd0, 6'd0, 7'd0, 64'd0, 8'd0));
    send_word(mk_word(OP_READ, VT_U16, 8'd0, 6'd0, 7'd127, 64'd0, 8'd0));
    send_word(mk_word(OP_READ, VT_UNKNOWN_LO, 8'd0, 6'd0, 7'd8, 64'd0, 8'd0));
    send_word(mk_word(OP_SPARE, VT_UNKNOWN_HI, 8'd0, 6'd0, 7'd8, 64'd0, 8'd0));
    // widest bit offset, nine bytes wide
    send_word(typed_word(OP_READ,  VT_U64,  8'd200, 6'd63, 64'd0));
  endtask

  // frame length at and beyond its limits, and big endian fields
  task automatic test_config_extremes();
    set_config(1'b0, 9'd0);
    send_word(typed_word(OP_READ,  VT_U8,   8'd0,   6'd0, 64'd0));
    send_word(typed_word(OP_WRITE, VT_U16,  8'd0,   6'd0, 64'h1234));
    send_word(typed_word(OP_READ,  VT_BOOL, 8'd0,   6'd0, 64'd0));
    // loads ignore the frame length
    send_word(mk_word(OP_LOAD, VT_BOOL, 8'd200, 6'd0, 7'd0, 64'd0, 8'hA5));
    set_config(1'b0, 9'd1);
    send_word(typed_word(OP_READ,  VT_U8,   8'd0,   6'd0, 64'd0));
    send_word(typed_word(OP_READ,  VT_U8,   8'd1,   6'd0, 64'd0));
    send_word(typed_word(OP_READ,  VT_BOOL, 8'd0,   6'd7, 64'd0));
    send_word(typed_word(OP_READ,  VT_BOOL, 8'd0,   6'd8, 64'd0));
    // oversized length acts as the full store
    set_config(1'b0, 9'd511);
    send_word(typed_word(OP_READ,  VT_U8,   8'd255, 6'd0, 64'd0));
    send_word(typed_word(OP_READ,  VT_U16,  8'd255, 6'd0, 64'd0));
    set_config(1'b1, 9'd256);
    send_word(typed_word(OP_READ,  VT_U16,  8'd0,   6'd0, 64'd0));
    send_word(typed_word(OP_WRITE, VT_U64,  8'd40,  6'd0, 64'h0123_4567_89AB_CDEF));
    send_word(typed_word(OP_READ,  VT_U64,  8'd40,  6'd0, 64'd0));
    send_word(typed_word(OP_READ,  VT_S16,  8'd40,  6'd0, 64'd0));
    // a bit offset falls back to lsb-first order
    send_word(typed_word(OP_READ,  VT_U16,  8'd40,  6'd3, 64'd0));
    send_word(typed_word(OP_WRITE, VT_S32,  8'd44,  6'd0, 64'hFFFF_FFFF_8000_0001));
    send_word(typed_word(OP_READ,  VT_U32,  8'd44,  6'd0, 64'd0));
  endtask

  task automatic test_random_traffic(input logic big, input logic [8:0] len,
                                     input int unsigned snd, input int unsigned rcv);
    set_config(big, len);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    repeat (PHASE_WORDS) send_word(random_field_word());
  endtask

  // response side holds off long enough for the core to stop taking words
  task automatic test_output_backpressure();
    set_config(1'b1, 9'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (60) send_word(random_field_word());
  endtask

  initial begin
    // every core input at a known level from time zero
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_BYTE_ORDER;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_LOAD;
    in_ch.byte_offset = '0;
    in_ch.bit_ofs     = '0;
    in_ch.field_width = '0;
    in_ch.field_type  = VT_BOOL;
    in_ch.write_value = '0;
    in_ch.load_byte   = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 0;
    hold_left         = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    order_big         = 1'b0;
    frame_len_q       = FRAME_LENGTH_RESET;
    foreach (frame_mem[i]) frame_mem[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_frame();
    test_directed_fields();
    test_config_extremes();
    test_random_traffic(1'b0, 9'd256, 0,  0);
    test_random_traffic(1'b1, 9'd256, 59, 0);
    test_random_traffic(1'b0, 9'd137, 0,  59);
    test_random_traffic(1'b1, 9'd9,   33, 33);
    test_random_traffic(1'b0, 9'd511, 33, 33);
    test_random_traffic(1'b1, 9'd64,  59, 0);
    test_output_backpressure();
    wait_idle();

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ffei_pkg.sv
design/ffei_in_if.sv
design/ffei_out_if.sv
design/frame_field_extract_insert_core.sv
tb/frame_field_extract_insert_core_tb.sv
